/* rtl/tkf_pkg.sv */
// Shared constants, types and helpers for the top-k frequent values block.
package tkf_pkg;

  localparam int MAX_DISTINCT = 256;
  localparam int MAX_WANTED   = 64;
  localparam int COUNT_BITS   = 16;

  localparam int IDX_W  = $clog2(MAX_DISTINCT);
  localparam int USED_W = $clog2(MAX_DISTINCT + 1);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [USED_W-1:0]     used_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_ZERO     = 2'd2,
    ST_TOO_MANY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_EMIT
  } fsm_e;

  // One table entry as it sits in a cell.
  typedef struct packed {
    logic        valid;
    logic        taken;
    logic [31:0] key;
    count_t      count;
  } entry_t;

  // Operation applied to every cell in a cycle.
  typedef struct packed {
    logic load;
    logic rotate;
    logic clear;
  } cell_ctl_t;

  // Clip a count to the 16-bit result field.
  function automatic logic [15:0] freq_clip(count_t c);
    logic [31:0] w;
    w = 32'(c);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

endpackage

/* rtl/tkf_cell.sv */
// One cell of the table: holds a single value, its count and its flags.
module tkf_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tkf_pkg::cell_ctl_t ctl_i,
  input  logic [31:0]       value_i,
  input  logic              hit_any_i,
  input  logic              prev_valid_i,
  input  tkf_pkg::entry_t   next_i,
  output tkf_pkg::entry_t   cur_o,
  output logic              match_o
);
  import tkf_pkg::*;

  logic   valid_q, valid_d, taken_q, taken_d;
  logic [31:0] key_q, key_d;
  count_t count_q, count_d;

  assign match_o = valid_q && (key_q == value_i);
  assign cur_o   = '{valid: valid_q, taken: taken_q, key: key_q, count: count_q};

  // Clear the flags, rotate along the row, count a matching value, or claim the first free cell.
  always_comb begin
    valid_d = valid_q;
    taken_d = taken_q;
    key_d   = key_q;
    count_d = count_q;
    if (ctl_i.clear) begin
      valid_d = 1'b0;
      taken_d = 1'b0;
    end else if (ctl_i.rotate) begin
      valid_d = next_i.valid;
      taken_d = next_i.taken;
      key_d   = next_i.key;
      count_d = next_i.count;
    end else if (ctl_i.load) begin
      if (match_o) begin
        if (count_q != '1) begin
          count_d = count_q + count_t'(1);
        end
      end else if (!hit_any_i && !valid_q && prev_valid_i) begin
        valid_d = 1'b1;
        taken_d = 1'b0;
        key_d   = value_i;
        count_d = count_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      taken_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      taken_q <= taken_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    count_q <= count_d;
  end

endmodule

/* rtl/top_k_frequent_values.sv */
// Top level: row of counting cells with a rotating max-search sequencer.
//
//  channel | signals                                        | direction
//  input   | in_valid_i, in_stall_o, command_i, value_i,    | into block
//          | count_wanted_i                                 |
//  output  | out_valid_o, out_stall_i, top_value_o,         | out of block
//          | frequency_o, last_o, status_o                  |
//
// In a load transfer every cell compares against the value at once.
// A finish transfer that is valid makes one full rotation of the row
// per emitted result and then hands that result over; an error result is
// handed over without a rotation. Reset clears all valid flags at once.
// A stalled output holds the result register and the sequencer waits on it.
module top_k_frequent_values (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [31:0] value_i,
  input  logic [6:0]  count_wanted_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] top_value_o,
  output logic [15:0] frequency_o,
  output logic        last_o,
  output logic [1:0]  status_o
);
  import tkf_pkg::*;

  fsm_e      state_q, state_d;
  cell_ctl_t ctl;
  entry_t    cells [MAX_DISTINCT];
  entry_t    wrap;
  logic [MAX_DISTINCT-1:0] match;
  logic      hit_any, accept, head_taken, cand;

  used_t   used_q, used_d;
  logic    ovf_q, ovf_d;
  logic [6:0] rem_q, rem_d;
  idx_t    step_q, step_d, best_idx_q, best_idx_d, prev_q, prev_d;
  logic    have_q, have_d, have_prev_q, have_prev_d;
  logic [31:0] best_key_q, best_key_d;
  count_t  best_cnt_q, best_cnt_d;
  status_e err_q, err_d;

  logic        ov_q, ov_d, olast_q, olast_d;
  logic [31:0] oval_q, oval_d;
  logic [15:0] ofreq_q, ofreq_d;
  status_e     ost_q, ost_d;
  logic        out_free;

  assign in_stall_o = (state_q != FSM_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign hit_any    = |match;
  assign out_free   = !(ov_q && out_stall_i);

  // The head entry leaves the row marked if it was the previous winner.
  assign head_taken = cells[0].taken || (have_prev_q && step_q == prev_q);
  assign wrap = '{valid: cells[0].valid, taken: head_taken,
                  key: cells[0].key, count: cells[0].count};
  assign cand = cells[0].valid && !head_taken && (!have_q || cells[0].count > best_cnt_q);

  // Row of cells; each rotates into its lower neighbour, the head wraps to the tail.
  for (genvar g = 0; g < MAX_DISTINCT; g++) begin : g_cell
    tkf_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .value_i      (value_i),
      .hit_any_i    (hit_any),
      .prev_valid_i ((g == 0) ? 1'b1 : cells[(g == 0) ? 0 : g-1].valid),
      .next_i       ((g == MAX_DISTINCT-1) ? wrap : cells[(g == MAX_DISTINCT-1) ? 0 : g+1]),
      .cur_o        (cells[g]),
      .match_o      (match[g])
    );
  end

  // Sequencer: next state, cell control and result register loading.
  always_comb begin
    state_d     = state_q;
    ctl         = '0;
    used_d      = used_q;
    ovf_d       = ovf_q;
    rem_d       = rem_q;
    step_d      = step_q;
    best_idx_d  = best_idx_q;
    prev_d      = prev_q;
    have_d      = have_q;
    have_prev_d = have_prev_q;
    best_key_d  = best_key_q;
    best_cnt_d  = best_cnt_q;
    err_d       = err_q;
    ov_d        = ov_q && out_stall_i;
    oval_d      = oval_q;
    ofreq_d     = ofreq_q;
    olast_d     = olast_q;
    ost_d       = ost_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (accept && !command_i) begin
          ctl.load = 1'b1;
          if (!hit_any) begin
            if (cells[MAX_DISTINCT-1].valid) begin
              ovf_d = 1'b1;
            end else begin
              used_d = used_q + used_t'(1);
            end
          end
        end else if (accept) begin
          rem_d       = count_wanted_i;
          step_d      = '0;
          have_d      = 1'b0;
          have_prev_d = 1'b0;
          state_d     = FSM_EMIT;
          if (ovf_q) begin
            err_d = ST_OVERFLOW;
          end else if (count_wanted_i == 7'd0) begin
            err_d = ST_ZERO;
          end else if (32'(count_wanted_i) > 32'(used_q) ||
                       32'(count_wanted_i) > 32'(MAX_WANTED)) begin
            err_d = ST_TOO_MANY;
          end else begin
            err_d   = ST_OK;
            state_d = FSM_SCAN;
          end
        end
      end
      FSM_SCAN: begin
        ctl.rotate = 1'b1;
        if (cand) begin
          have_d     = 1'b1;
          best_idx_d = step_q;
          best_key_d = cells[0].key;
          best_cnt_d = cells[0].count;
        end
        if (step_q == idx_t'(MAX_DISTINCT-1)) begin
          state_d = FSM_EMIT;
        end
        step_d = step_q + idx_t'(1);
      end
      FSM_EMIT: begin
        if (out_free) begin
          ov_d = 1'b1;
          if (err_q != ST_OK) begin
            oval_d  = '0;
            ofreq_d = '0;
            olast_d = 1'b1;
            ost_d   = err_q;
          end else begin
            oval_d  = best_key_q;
            ofreq_d = freq_clip(best_cnt_q);
            olast_d = (rem_q == 7'd1);
            ost_d   = ST_OK;
          end
          if (err_q != ST_OK || rem_q == 7'd1) begin
            ctl.clear = 1'b1;
            used_d    = '0;
            ovf_d     = 1'b0;
            state_d   = FSM_IDLE;
          end else begin
            rem_d       = rem_q - 7'd1;
            prev_d      = best_idx_q;
            have_prev_d = 1'b1;
            have_d      = 1'b0;
            step_d      = '0;
            state_d     = FSM_SCAN;
          end
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      used_q      <= '0;
      ovf_q       <= 1'b0;
      ov_q        <= 1'b0;
      have_q      <= 1'b0;
      have_prev_q <= 1'b0;
      step_q      <= '0;
      rem_q       <= '0;
      err_q       <= ST_OK;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      ovf_q       <= ovf_d;
      ov_q        <= ov_d;
      have_q      <= have_d;
      have_prev_q <= have_prev_d;
      step_q      <= step_d;
      rem_q       <= rem_d;
      err_q       <= err_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    best_idx_q <= best_idx_d;
    prev_q     <= prev_d;
    best_key_q <= best_key_d;
    best_cnt_q <= best_cnt_d;
    oval_q     <= oval_d;
    ofreq_q    <= ofreq_d;
    olast_q    <= olast_d;
    ost_q      <= ost_d;
  end

  assign out_valid_o = ov_q;
  assign top_value_o = oval_q;
  assign frequency_o = ofreq_q;
  assign last_o      = olast_q;
  assign status_o    = ost_q;

endmodule
